// ----- rtl/tqls_pkg.sv -----
// shared types and constants of the tabular q-learning step core
`timescale 1ns / 1ps
package tqls_pkg;

  localparam int ACTIONS = 4;
  localparam int ACT_W   = 2;

  // q1.8 one, for alpha and gamma
  localparam logic [8:0] Q_ONE = 9'd256;

  // register indexes
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_GAMMA = 2'd1;
  localparam logic [1:0] REG_EPS   = 2'd2;
  localparam logic [1:0] REG_START = 2'd3;

  localparam logic [8:0] ALPHA_RST = 9'd205;
  localparam logic [8:0] GAMMA_RST = 9'd154;
  localparam logic [6:0] EPS_RST   = 7'd5;
  localparam logic [7:0] START_RST = 8'd0;

  // stage loads of the update datapath
  typedef struct packed {
    logic ld_max;
    logic ld_pg;
    logic ld_pa;
    logic ld_nv;
  } tqls_upd_ctl_t;

endpackage

// ----- rtl/tqls_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tqls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tqls_update.sv -----
// staged fixed-point q value update with rounding and saturation
`timescale 1ns / 1ps
module tqls_update #(
  parameter int VALUE_BITS = 16
) (
  input  logic                                          clk,
  input  tqls_pkg::tqls_upd_ctl_t                       ctl,
  input  logic signed [VALUE_BITS-1:0]                  q_old,
  input  logic [tqls_pkg::ACTIONS*VALUE_BITS-1:0]       nxt_row,
  input  logic signed [15:0]                            reward,
  input  logic [8:0]                                    alpha_c,
  input  logic [8:0]                                    gamma_c,
  output logic signed [VALUE_BITS-1:0]                  nv
);
  import tqls_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int PQ_W  = VB + 10;
  localparam int TW    = ((VB + 10 > 24) ? VB + 10 : 24) + 1;
  localparam int PA_W  = TW + 10;
  localparam int ACC_W = PA_W + 2;

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [VB-1:0]    NV_HI  = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0]    NV_LO  = ~NV_HI;
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(32768);

  logic signed [VB-1:0]    nq [ACTIONS];
  logic signed [VB-1:0]    mx;
  logic signed [VB-1:0]    mx_r;
  logic signed [9:0]       om_s;
  logic signed [9:0]       a_s;
  logic signed [9:0]       g_s;
  logic signed [PQ_W-1:0]  pq;
  logic signed [PQ_W-1:0]  pg;
  logic signed [TW-1:0]    tgt;
  logic signed [PA_W-1:0]  pa;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sh;

  for (genvar i = 0; i < ACTIONS; i++) begin : g_unpack
    assign nq[i] = nxt_row[i*VB +: VB];
  end

  always_comb begin
    mx = nq[0];
    for (int i = 1; i < ACTIONS; i++) begin
      if (nq[i] > mx) begin
        mx = nq[i];
      end
    end
  end

  assign om_s = $signed({1'b0, Q_ONE - alpha_c});
  assign a_s  = $signed({1'b0, alpha_c});
  assign g_s  = $signed({1'b0, gamma_c});
  assign tgt  = (TW'(reward) <<< 8) + TW'(pg);
  assign acc  = (ACC_W'(pq) <<< 8) + ACC_W'(pa) + HALF;
  assign sh   = acc >>> 16;

  always_ff @(posedge clk) begin
    if (ctl.ld_max) begin
      mx_r <= mx;
      pq   <= q_old * om_s;
    end
    if (ctl.ld_pg) begin
      pg <= mx_r * g_s;
    end
    if (ctl.ld_pa) begin
      pa <= tgt * a_s;
    end
    if (ctl.ld_nv) begin
      if (sh > SAT_HI) begin
        nv <= NV_HI;
      end else if (sh < SAT_LO) begin
        nv <= NV_LO;
      end else begin
        nv <= VB'(sh);
      end
    end
  end

endmodule

// ----- rtl/tqls_choose.sv -----
// epsilon-greedy action choice over one table row
`timescale 1ns / 1ps
module tqls_choose #(
  parameter int VALUE_BITS = 16
) (
  input  logic [tqls_pkg::ACTIONS*VALUE_BITS-1:0] row,
  input  logic [6:0]                              explore_draw,
  input  logic [6:0]                              epsilon,
  input  logic [tqls_pkg::ACT_W-1:0]              random_action,
  input  logic [tqls_pkg::ACT_W-1:0]              tie_start,
  output logic [tqls_pkg::ACT_W-1:0]              action,
  output logic                                    explored
);
  import tqls_pkg::*;

  localparam int VB = VALUE_BITS;

  logic signed [VB-1:0] q [ACTIONS];
  logic signed [VB-1:0] best;
  logic [ACT_W-1:0]     dir;

  for (genvar i = 0; i < ACTIONS; i++) begin : g_unpack
    assign q[i] = row[i*VB +: VB];
  end

  always_comb begin
    dir  = tie_start;
    best = q[tie_start];
    for (int i = 0; i < ACTIONS; i++) begin
      if (q[i] > best) begin
        best = q[i];
        dir  = ACT_W'(i);
      end
    end
  end

  assign explored = explore_draw < epsilon;
  assign action   = explored ? random_action : dir;

endmodule

// ----- rtl/tabular_q_learning_step_core.sv -----
// top level of the tabular q-learning step core
//
//  channel   direction  handshake              payload
//  item      in         start & !busy          begin_episode next_state reward done_req
//                                              explore_draw random_action tie_start
//  result    out        result_valid (1 cycle) action explored episode_over new_value
//  config    in         apb write, pready = 1  alpha gamma epsilon_percent start_state
//
// a step item makes two row reads through the single ram read port, then runs the
// multiply chain of the update unit and a write-back.
// a begin item does one row read and the action choice.
// after reset the table is cleared one row a cycle, all STATES rows, with busy high.
// the result shows in the cycle after the last stage; the receiver cannot stall.
`timescale 1ns / 1ps
module tabular_q_learning_step_core #(
  parameter int STATES     = 256,
  parameter int VALUE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               begin_episode,
  input  logic [7:0]         next_state,
  input  logic signed [15:0] reward,
  input  logic               done_req,
  input  logic [6:0]         explore_draw,
  input  logic [1:0]         random_action,
  input  logic [1:0]         tie_start,
  output logic               result_valid,
  output logic [1:0]         action,
  output logic               explored,
  output logic               episode_over,
  output logic signed [15:0] new_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tqls_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int SW    = $clog2(STATES);
  localparam int ROW_W = ACTIONS * VB;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_RD2   = 9'b000000100,
    ST_MAX   = 9'b000001000,
    ST_PG    = 9'b000010000,
    ST_PA    = 9'b000100000,
    ST_NV    = 9'b001000000,
    ST_WB    = 9'b010000000,
    ST_BEGIN = 9'b100000000
  } tqls_state_t;

  tqls_state_t state, state_next;

  logic [8:0]  alpha;
  logic [8:0]  gamma;
  logic [6:0]  epsilon;
  logic [7:0]  start_st;

  logic [SW-1:0] wrap_tab [256];
  logic [SW-1:0] clr_cnt;
  logic [SW-1:0] cs;
  logic [SW-1:0] nxt_r;
  logic [ACT_W-1:0] la;

  logic signed [15:0] reward_r;
  logic               done_r;
  logic [6:0]         draw_r;
  logic [ACT_W-1:0]   rnd_r;
  logic [ACT_W-1:0]   tie_r;

  logic               accept;
  logic               cfg_wr;
  logic               ram_we;
  logic [SW-1:0]      ram_waddr;
  logic [ROW_W-1:0]   ram_wdata;
  logic [SW-1:0]      ram_raddr;
  logic [ROW_W-1:0]   ram_rdata;

  logic [ROW_W-1:0]   cur_row;
  logic [ROW_W-1:0]   nxt_row;
  logic [ROW_W-1:0]   upd_row;
  logic [ROW_W-1:0]   ch_row;
  logic signed [VB-1:0] cur_q [ACTIONS];
  logic signed [VB-1:0] nv;
  logic signed [31:0]   nv_ext;
  logic [8:0]         alpha_c;
  logic [8:0]         gamma_c;
  logic [ACT_W-1:0]   ch_action;
  logic               ch_explored;
  tqls_upd_ctl_t      upd_ctl;

  for (genvar g = 0; g < 256; g++) begin : g_wrap
    assign wrap_tab[g] = SW'(g % STATES);
  end

  for (genvar i = 0; i < ACTIONS; i++) begin : g_row
    assign cur_q[i] = cur_row[i*VB +: VB];
    assign upd_row[i*VB +: VB] = (la == ACT_W'(i)) ? nv : cur_row[i*VB +: VB];
  end

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha    <= ALPHA_RST;
      gamma    <= GAMMA_RST;
      epsilon  <= EPS_RST;
      start_st <= START_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ALPHA: alpha    <= pwdata[8:0];
        REG_GAMMA: gamma    <= pwdata[8:0];
        REG_EPS:   epsilon  <= pwdata[6:0];
        REG_START: start_st <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ALPHA: prdata = {23'd0, alpha};
      REG_GAMMA: prdata = {23'd0, gamma};
      REG_EPS:   prdata = {25'd0, epsilon};
      REG_START: prdata = {24'd0, start_st};
      default:   prdata = 32'd0;
    endcase
  end

  assign alpha_c = (alpha > Q_ONE) ? Q_ONE : alpha;
  assign gamma_c = (gamma > Q_ONE) ? Q_ONE : gamma;

  // control
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == SW'(STATES - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = begin_episode ? ST_BEGIN : ST_RD2;
      ST_RD2:   state_next = ST_MAX;
      ST_MAX:   state_next = ST_PG;
      ST_PG:    state_next = ST_PA;
      ST_PA:    state_next = ST_NV;
      ST_NV:    state_next = ST_WB;
      ST_WB:    state_next = ST_IDLE;
      ST_BEGIN: state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      nxt_r    <= begin_episode ? wrap_tab[start_st] : wrap_tab[next_state];
      reward_r <= reward;
      done_r   <= done_req;
      draw_r   <= explore_draw;
      rnd_r    <= random_action;
      tie_r    <= tie_start;
    end
    if (state == ST_RD2) begin
      cur_row <= ram_rdata;
    end
    if (state == ST_MAX) begin
      nxt_row <= ram_rdata;
    end
  end

  // table access
  always_comb begin
    if (state == ST_IDLE) begin
      ram_raddr = begin_episode ? wrap_tab[start_st] : cs;
    end else begin
      ram_raddr = nxt_r;
    end
  end

  assign ram_we    = (state == ST_CLEAR) || (state == ST_WB);
  assign ram_waddr = (state == ST_CLEAR) ? clr_cnt : cs;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : upd_row;

  tqls_ram #(
    .WIDTH (ROW_W),
    .DEPTH (STATES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign upd_ctl.ld_max = (state == ST_MAX);
  assign upd_ctl.ld_pg  = (state == ST_PG);
  assign upd_ctl.ld_pa  = (state == ST_PA);
  assign upd_ctl.ld_nv  = (state == ST_NV);

  tqls_update #(
    .VALUE_BITS (VB)
  ) u_update (
    .clk     (clk),
    .ctl     (upd_ctl),
    .q_old   (cur_q[la]),
    .nxt_row (ram_rdata),
    .reward  (reward_r),
    .alpha_c (alpha_c),
    .gamma_c (gamma_c),
    .nv      (nv)
  );

  // forward the written row when the next state is the current one (a begin item uses the row just read)
  always_comb begin
    if (state == ST_BEGIN) begin
      ch_row = ram_rdata;
    end else if (nxt_r == cs) begin
      ch_row = upd_row;
    end else begin
      ch_row = nxt_row;
    end
  end

  tqls_choose #(
    .VALUE_BITS (VB)
  ) u_choose (
    .row           (ch_row),
    .explore_draw  (draw_r),
    .epsilon       (epsilon),
    .random_action (rnd_r),
    .tie_start     (tie_r),
    .action        (ch_action),
    .explored      (ch_explored)
  );

  assign nv_ext = 32'(nv);

  always_ff @(posedge clk) begin
    if (rst) begin
      cs           <= '0;
      la           <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_WB) || (state == ST_BEGIN);
      if (state == ST_BEGIN) begin
        cs <= nxt_r;
        la <= ch_action;
      end else if ((state == ST_WB) && !done_r) begin
        cs <= nxt_r;
        la <= ch_action;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_BEGIN) begin
      action       <= ch_action;
      explored     <= ch_explored;
      episode_over <= 1'b0;
      new_value    <= '0;
    end else if (state == ST_WB) begin
      action       <= done_r ? '0 : ch_action;
      explored     <= done_r ? 1'b0 : ch_explored;
      episode_over <= done_r;
      new_value    <= nv_ext[15:0];
    end
  end

`ifndef SYNTHESIS
  a_result_src : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_WB || state == ST_BEGIN))
    else $error("result without a finished item");

  a_one_result : assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the core busy");
`endif

endmodule

// ----- tb/tqls_checker.sv -----
// checker for the q-learning step core: predicts each item's result and compares it
`timescale 1ns / 1ps
module tqls_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               begin_episode,
  input  logic [7:0]         next_state,
  input  logic signed [15:0] reward,
  input  logic               done_req,
  input  logic [6:0]         explore_draw,
  input  logic [1:0]         random_action,
  input  logic [1:0]         tie_start,
  input  logic               result_valid,
  input  logic [1:0]         action,
  input  logic               explored,
  input  logic               episode_over,
  input  logic signed [15:0] new_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 pending,
  output int                 checked
);
  import tqls_pkg::*;

  typedef struct packed {
    logic [1:0]         action;
    logic               explored;
    logic               episode_over;
    logic signed [15:0] new_value;
  } outcome_t;

  logic signed [15:0] q_tab [256][ACTIONS];
  logic [7:0]         cur_state;
  logic [1:0]         last_act;
  logic [8:0]         alpha_r;
  logic [8:0]         gamma_r;
  logic [6:0]         eps_r;
  logic [7:0]         start_r;
  outcome_t           outcome_q[$];
  int                 err_cnt;
  int                 chk_cnt;

  function automatic logic [1:0] pick_action(input logic [7:0] s, input logic [6:0] draw,
                                             input logic [1:0] rnd, input logic [1:0] tie,
                                             output logic expl);
    logic [1:0]         best;
    logic signed [15:0] best_v;
    if (draw < eps_r) begin
      expl = 1'b1;
      return rnd;
    end
    expl   = 1'b0;
    best   = tie;
    best_v = q_tab[s][tie];
    for (int i = 0; i < ACTIONS; i++) begin
      if (q_tab[s][i] > best_v) begin
        best_v = q_tab[s][i];
        best   = 2'(i);
      end
    end
    return best;
  endfunction

  function automatic outcome_t predict_step(input logic bgn, input logic [7:0] nxt,
                                            input logic signed [15:0] rwd, input logic dn,
                                            input logic [6:0] draw, input logic [1:0] rnd,
                                            input logic [1:0] tie);
    outcome_t o;
    longint   a_eff;
    longint   g_eff;
    longint   row_max;
    longint   target;
    longint   acc;
    longint   nv;
    logic     expl;
    o = '0;
    if (bgn) begin
      cur_state  = start_r;
      o.action   = pick_action(cur_state, draw, rnd, tie, expl);
      o.explored = expl;
      last_act   = o.action;
    end else begin
      a_eff   = (alpha_r > Q_ONE) ? longint'(Q_ONE) : longint'(alpha_r);
      g_eff   = (gamma_r > Q_ONE) ? longint'(Q_ONE) : longint'(gamma_r);
      row_max = longint'(q_tab[nxt][0]);
      for (int i = 1; i < ACTIONS; i++)
        if (longint'(q_tab[nxt][i]) > row_max) row_max = longint'(q_tab[nxt][i]);
      target = longint'(rwd) * 256 + g_eff * row_max;
      acc    = longint'(q_tab[cur_state][last_act]) * (256 - a_eff) * 256 + a_eff * target;
      // round to nearest q8.8 step, ties upward
      nv = (acc + 32768) >>> 16;
      if (nv > 32767) nv = 32767;
      if (nv < -32768) nv = -32768;
      q_tab[cur_state][last_act] = 16'(nv);
      o.new_value = 16'(nv);
      if (dn) begin
        o.episode_over = 1'b1;
      end else begin
        cur_state  = nxt;
        o.action   = pick_action(nxt, draw, rnd, tie, expl);
        o.explored = expl;
        last_act   = o.action;
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      foreach (q_tab[s, a]) q_tab[s][a] = '0;
      cur_state = '0;
      last_act  = '0;
      alpha_r   = ALPHA_RST;
      gamma_r   = GAMMA_RST;
      eps_r     = EPS_RST;
      start_r   = START_RST;
      outcome_q.delete();
      err_cnt   = 0;
      chk_cnt   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ALPHA: alpha_r = pwdata[8:0];
          REG_GAMMA: gamma_r = pwdata[8:0];
          REG_EPS:   eps_r   = pwdata[6:0];
          REG_START: start_r = pwdata[7:0];
          default: ;
        endcase
      end
      if (start && !busy)
        outcome_q.push_back(predict_step(begin_episode, next_state, reward, done_req,
                                         explore_draw, random_action, tie_start));
      if (result_valid) begin
        if (outcome_q.size() == 0) begin
          $error("result with no item outstanding");
          err_cnt++;
        end else begin
          want = outcome_q.pop_front();
          chk_cnt++;
          if (action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, action);
            err_cnt++;
          end
          if (explored !== want.explored) begin
            $error("explored: expected %0d, got %0d", want.explored, explored);
            err_cnt++;
          end
          if (episode_over !== want.episode_over) begin
            $error("episode_over: expected %0d, got %0d", want.episode_over, episode_over);
            err_cnt++;
          end
          if (new_value !== want.new_value) begin
            $error("new_value: expected %0d, got %0d", want.new_value, new_value);
            err_cnt++;
          end
        end
      end
    end
    errors  <= err_cnt;
    pending <= outcome_q.size();
    checked <= chk_cnt;
  end

endmodule

// ----- tb/tb_top.sv -----
// testbench top: drives items and register writes into the q-learning step core
`timescale 1ns / 1ps
module tb_top;
  import tqls_pkg::*;

  localparam int LIMIT     = 300000;
  localparam int SEGMENTS  = 6;
  localparam int SEG_ITEMS = 305;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               begin_episode = 1'b0;
  logic [7:0]         next_state = '0;
  logic signed [15:0] reward = '0;
  logic               done_req = 1'b0;
  logic [6:0]         explore_draw = '0;
  logic [1:0]         random_action = '0;
  logic [1:0]         tie_start = '0;
  logic               result_valid;
  logic [1:0]         action;
  logic               explored;
  logic               episode_over;
  logic signed [15:0] new_value;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors;
  int                 pending;
  int                 checked;
  int                 idle_pct = 0;
  int                 n_sent = 0;
  int unsigned        cycle_cnt = 0;

  tabular_q_learning_step_core dut (.*);
  tqls_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt == LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] rand_state();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 15));
    return 8'($urandom);
  endfunction

  function automatic logic signed [15:0] rand_reward();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  task automatic drive_item(input logic bgn, input logic [7:0] nxt,
                            input logic signed [15:0] rwd, input logic dn,
                            input logic [6:0] draw, input logic [1:0] rnd,
                            input logic [1:0] tie);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start         <= 1'b1;
    begin_episode <= bgn;
    next_state    <= nxt;
    reward        <= rwd;
    done_req      <= dn;
    explore_draw  <= draw;
    random_action <= rnd;
    tie_start     <= tie;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  task automatic random_item(input logic bgn, input logic dn);
    drive_item(bgn, rand_state(), rand_reward(), dn, 7'($urandom_range(0, 127)),
               2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endtask

  // wait until every item's result is in and the core is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_episode(input int stop_at);
    int len;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 8);
    random_item(1'b1, 1'($urandom_range(0, 1)));
    for (int k = 0; k < len && n_sent < stop_at; k++)
      random_item(1'b0, 1'(k == len - 1));
  endtask

  initial begin
    logic [8:0] a_val;
    logic [8:0] g_val;
    logic [6:0] e_val;
    logic [7:0] s_val;
    int         stop_at;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    drain();

    // directed items at reset settings
    drive_item(1'b1, 8'd0,   16'sd0,    1'b0, 7'd127, 2'd0, 2'd2);
    drive_item(1'b1, 8'd255, 16'h8000,  1'b1, 7'd0,   2'd3, 2'd1);
    drive_item(1'b0, 8'd255, 16'h7fff,  1'b0, 7'd127, 2'd1, 2'd3);
    drive_item(1'b0, 8'd0,   16'h8000,  1'b0, 7'd100, 2'd2, 2'd0);
    drive_item(1'b0, 8'd0,   16'sd256,  1'b0, 7'd4,   2'd1, 2'd0);
    drive_item(1'b0, 8'd0,   16'sd512,  1'b0, 7'd5,   2'd0, 2'd1);
    drive_item(1'b0, 8'd1,   16'sd384,  1'b1, 7'd127, 2'd0, 2'd0);
    drive_item(1'b0, 8'd2,   -16'sd100, 1'b0, 7'd127, 2'd0, 2'd3);
    drive_item(1'b0, 8'd2,   16'sd0,    1'b1, 7'd64,  2'd2, 2'd2);
    drive_item(1'b0, 8'd3,   16'sd1,    1'b1, 7'd127, 2'd1, 2'd1);
    drive_item(1'b1, 8'd7,   16'sd999,  1'b1, 7'd127, 2'd0, 2'd0);
    drive_item(1'b0, 8'd0,   16'sd128,  1'b0, 7'd127, 2'd0, 2'd3);
    drive_item(1'b0, 8'd0,   -16'sd1,   1'b0, 7'd127, 2'd0, 2'd1);
    drive_item(1'b0, 8'd1,   16'sd2048, 1'b0, 7'd127, 2'd0, 2'd2);
    drive_item(1'b0, 8'd1,   16'sd1,    1'b0, 7'd127, 2'd0, 2'd0);
    drive_item(1'b1, 8'd0,   16'sd0,    1'b0, 7'd127, 2'd0, 2'd3);
    drive_item(1'b1, 8'd0,   16'sd0,    1'b0, 7'd3,   2'd2, 2'd0);
    drive_item(1'b0, 8'd128, 16'h7fff,  1'b0, 7'd126, 2'd1, 2'd1);
    drive_item(1'b0, 8'd128, 16'h7fff,  1'b0, 7'd127, 2'd3, 2'd2);
    drive_item(1'b0, 8'd255, 16'h8000,  1'b1, 7'd1,   2'd0, 2'd3);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      case (seg)
        0:       begin a_val = 9'd256; g_val = 9'd256; e_val = 7'd0;   s_val = 8'd255; end
        1:       begin a_val = 9'd0;   g_val = 9'd0;   e_val = 7'd100; s_val = 8'd17;  end
        2:       begin a_val = 9'd511; g_val = 9'd511; e_val = 7'd127; s_val = 8'd3;   end
        3:       begin a_val = 9'd128; g_val = 9'd230; e_val = 7'd30;  s_val = 8'd0;   end
        4:       begin a_val = 9'd64;  g_val = 9'd200; e_val = 7'd10;  s_val = 8'd200; end
        default: begin a_val = 9'd257; g_val = 9'd0;   e_val = 7'd50;  s_val = 8'd5;   end
      endcase
      apb_write(REG_ALPHA, 32'(a_val));
      apb_write(REG_GAMMA, 32'(g_val));
      apb_write(REG_EPS,   32'(e_val));
      apb_write(REG_START, 32'(s_val));
      idle_pct = (seg < 2) ? 17 : (seg < 4) ? 55 : 0;
      stop_at  = n_sent + SEG_ITEMS;
      while (n_sent < stop_at) begin
        if ($urandom_range(0, 99) < 12)
          random_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else
          run_episode(stop_at);
        if ($urandom_range(0, 99) < 2) drain();
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    $display("covered %0d items, %0d results checked, over %0d register settings",
             n_sent, checked, SEGMENTS + 1);
    $display("sender gaps at 17%% and 55%% and none, with drained pauses between");
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tqls_pkg.sv
rtl/tqls_ram.sv
rtl/tqls_update.sv
rtl/tqls_choose.sv
rtl/tabular_q_learning_step_core.sv
tb/tqls_checker.sv
tb/tb_top.sv
